// ===== sv/lafe_pkg.sv =====
// Shared types and constants of the LMS adaptive FIR equalizer.
package lafe_pkg;

	localparam int TAP_COUNT = 64;
	localparam int PRE_TAPS  = 51;

	localparam int SAMPLE_W = 16;
	localparam int TAP_W    = 24;
	localparam int STEP_W   = 18;
	localparam int CMD_W    = 2;
	localparam int CNT_W    = $clog2(TAP_COUNT);
	localparam int PROD_W   = SAMPLE_W + TAP_W;
	localparam int ACC_W    = PROD_W + $clog2(TAP_COUNT);
	localparam int ERR_W    = SAMPLE_W + 1;
	localparam int SE_W     = STEP_W + 1 + ERR_W;
	localparam int UPD_W    = SE_W + SAMPLE_W;

	localparam logic [STEP_W-1:0] STEP_RESET = 18'd214748;
	localparam logic signed [ERR_W-1:0] REF_POS = 17'sd5120;
	localparam logic signed [ERR_W-1:0] REF_NEG = -17'sd5120;

	localparam logic [CMD_W-1:0] CMD_FILTER = 2'd0;
	localparam logic [CMD_W-1:0] CMD_ADAPT  = 2'd1;
	localparam logic [CMD_W-1:0] CMD_SHIFT  = 2'd2;
	localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

	typedef struct packed {
		logic signed [SAMPLE_W-1:0] sample;
		logic [CMD_W-1:0]           cmd;
		logic                       ref_bit;
		logic                       segment_end;
	} in_item_t;

	typedef struct packed {
		logic signed [SAMPLE_W-1:0] equalized;
		logic                       last;
	} out_item_t;

	typedef struct packed {
		logic shift;
		logic rot;
	} cell_ctl_t;

endpackage

// ===== sv/lafe_cell.sv =====
// One tap cell: holds a window sample and its coefficient.
module lafe_cell import lafe_pkg::*; (
	input  logic                       clk,
	input  logic                       arst_n,
	input  cell_ctl_t                  ctl,
	input  logic signed [SAMPLE_W-1:0] w_in,
	input  logic signed [TAP_W-1:0]    c_in,
	output logic signed [SAMPLE_W-1:0] w,
	output logic signed [TAP_W-1:0]    c
);

	logic signed [SAMPLE_W-1:0] w_q;
	logic signed [TAP_W-1:0]    c_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			w_q <= '0;
			c_q <= '0;
		end else if (ctl.rot) begin
			w_q <= w_in;
			c_q <= c_in;
		end else if (ctl.shift) begin
			w_q <= w_in;
		end
	end

	assign w = w_q;
	assign c = c_q;

endmodule

// ===== sv/lms_adaptive_fir_equalizer_core.sv =====
// Top level of the LMS adaptive FIR equalizer: cell ring and head arithmetic.
// Shift-only item: one window shift, no ring pass. Filter item: a ring pass to the output
// register, one multiply-accumulate at the ring head per cycle.
// Adapt item: a ring pass, then a tap update pass; each tap update has a
// multiply step and a write-back step at the head. One item at a time.
// Reset clears window, taps and control at once; step_size returns to default.
module lms_adaptive_fir_equalizer_core import lafe_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  in_item_t            in_item,
	output logic                out_valid,
	input  logic                out_stall,
	output out_item_t           out_item,
	input  logic                cfg_we,
	input  logic [STEP_W-1:0]   cfg_wdata
);

	typedef enum logic [2:0] {
		ST_IDLE, ST_FILT, ST_FLUSH, ST_ERR, ST_SE, ST_AMUL, ST_AWR
	} state_t;

	state_t             state_q;
	logic [CNT_W-1:0]   cnt_q;
	logic [CMD_W-1:0]   cmd_q;
	logic               ref_q;
	logic               seg_q;
	logic [STEP_W-1:0]  step_q;
	logic               out_valid_q;
	out_item_t          out_q;

	// ring of cells; cell 0 is the head (oldest sample)
	logic signed [SAMPLE_W-1:0] w [TAP_COUNT];
	logic signed [TAP_W-1:0]    c [TAP_COUNT];
	logic signed [SAMPLE_W-1:0] w_nb [TAP_COUNT];
	logic signed [TAP_W-1:0]    c_nb [TAP_COUNT];
	cell_ctl_t                  ctl;

	logic accept;
	assign accept   = in_valid && !in_stall;
	assign in_stall = (state_q != ST_IDLE);

	assign ctl.shift = accept;
	assign ctl.rot   = (state_q == ST_FILT) || (state_q == ST_AWR);

	// head arithmetic
	logic signed [PROD_W-1:0] prod_s1;
	logic                     pv_s1;
	logic signed [ACC_W-1:0]  acc_q;
	logic signed [ERR_W-1:0]  e_q;
	logic signed [SE_W-1:0]   se_q;
	logic signed [UPD_W-1:0]  p_s1;

	// rounding Q15.30 to Q5.10 and saturation
	logic signed [ACC_W:0]          acc_rnd;
	logic signed [ACC_W-20:0]       y_wide;
	logic signed [SAMPLE_W-1:0]     y_sat;
	logic signed [ERR_W-1:0]        e_new;
	assign acc_rnd = {acc_q[ACC_W-1], acc_q} + (ACC_W+1)'(1 << 19);
	assign y_wide  = acc_rnd[ACC_W:20];
	always_comb begin
		if (y_wide > (ACC_W-19)'(32767))
			y_sat = 16'sh7fff;
		else if (y_wide < -(ACC_W-19)'(32768))
			y_sat = -16'sh8000;
		else
			y_sat = y_wide[SAMPLE_W-1:0];
	end
	assign e_new = {y_sat[SAMPLE_W-1], y_sat} - (ref_q ? REF_POS : REF_NEG);

	// tap update: round delta to Q3.20, subtract, saturate to 24 bits
	logic signed [UPD_W:0]    p_rnd;
	logic signed [UPD_W-32:0] delta;
	logic signed [TAP_W:0]    t_wide;
	logic signed [TAP_W-1:0]  c_upd;
	assign p_rnd  = {p_s1[UPD_W-1], p_s1} + (UPD_W+1)'(64'd1 << 31);
	assign delta  = p_rnd[UPD_W:32];
	assign t_wide = {c[0][TAP_W-1], c[0]} - (TAP_W+1)'(delta);
	always_comb begin
		if (t_wide > (TAP_W+1)'(8388607))
			c_upd = 24'sh7fffff;
		else if (t_wide < -(TAP_W+1)'(8388608))
			c_upd = -24'sh800000;
		else
			c_upd = t_wide[TAP_W-1:0];
	end

	// neighbour wiring: tail gets the new sample on shift, the head on rotate
	always_comb begin
		for (int k = 0; k < TAP_COUNT - 1; k++) begin
			w_nb[k] = w[k+1];
			c_nb[k] = c[k+1];
		end
		w_nb[TAP_COUNT-1] = ctl.rot ? w[0] : in_item.sample;
		c_nb[TAP_COUNT-1] = (state_q == ST_AWR) ? c_upd : c[0];
	end

	for (genvar k = 0; k < TAP_COUNT; k++) begin : g_cell
		lafe_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.ctl    (ctl),
			.w_in   (w_nb[k]),
			.c_in   (c_nb[k]),
			.w      (w[k]),
			.c      (c[k])
		);
	end

	// MAC pipeline and adapt multipliers; payload only
	always_ff @(posedge clk) begin
		prod_s1 <= w[0] * c[0];
		if (state_q == ST_ERR)
			e_q <= e_new;
		if (state_q == ST_SE)
			se_q <= $signed({1'b0, step_q}) * e_q;
		if (state_q == ST_AMUL)
			p_s1 <= se_q * w[0];
		if (accept) begin
			acc_q <= '0;
		end else if (pv_s1) begin
			acc_q <= acc_q + ACC_W'(prod_s1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= STEP_RESET;
		end else if (cfg_we) begin
			step_q <= cfg_wdata;
		end
	end

	// sequencer and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			cmd_q       <= CMD_FILTER;
			ref_q       <= 1'b0;
			seg_q       <= 1'b0;
			pv_s1       <= 1'b0;
			out_valid_q <= 1'b0;
			out_q       <= '0;
		end else begin
			pv_s1 <= (state_q == ST_FILT);
			if (out_valid_q && !out_stall)
				out_valid_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						cmd_q <= in_item.cmd;
						ref_q <= in_item.ref_bit;
						seg_q <= in_item.segment_end;
						if (in_item.cmd == CMD_FILTER || in_item.cmd == CMD_ADAPT)
							state_q <= ST_FILT;
					end
				end
				ST_FILT: begin
					if (cnt_q == CNT_W'(TAP_COUNT - 1)) begin
						cnt_q   <= '0;
						state_q <= ST_FLUSH;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				ST_FLUSH: state_q <= ST_ERR;
				ST_ERR: begin
					if (cmd_q == CMD_ADAPT) begin
						state_q <= ST_SE;
					end else if (!out_valid_q || !out_stall) begin
						out_valid_q     <= 1'b1;
						out_q.equalized <= y_sat;
						out_q.last      <= seg_q;
						state_q         <= ST_IDLE;
					end
				end
				ST_SE:   state_q <= ST_AMUL;
				ST_AMUL: state_q <= ST_AWR;
				ST_AWR: begin
					if (cnt_q == CNT_W'(TAP_COUNT - 1)) begin
						cnt_q   <= '0;
						state_q <= ST_IDLE;
					end else begin
						cnt_q   <= cnt_q + 1'b1;
						state_q <= ST_AMUL;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign out_valid = out_valid_q;
	assign out_item  = out_q;

	// filter and adapt items always start a ring pass
	a_start: assert property (@(posedge clk) disable iff (!arst_n)
		accept && (in_item.cmd == CMD_FILTER || in_item.cmd == CMD_ADAPT)
		|=> state_q == ST_FILT)
		else $error("ring pass not started");

	// the ring is back in its home position whenever the sequencer idles
	a_home: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_IDLE |-> cnt_q == '0)
		else $error("tap counter not home in idle");

	// accumulation is complete when the output is formed
	a_acc: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_ERR |-> !pv_s1)
		else $error("accumulator still busy at output");

	// a rotation step of the adapt pass always follows its multiply step
	a_awr: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_AWR |-> $past(state_q) == ST_AMUL)
		else $error("tap write without product");

endmodule
